>>> design/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types, constants and helpers for the rope constraint projection.
// ----------------------------------------------------------------------------
package rcp_pkg;

    localparam int SQRT_BITS = 34;
    localparam int RAD_W     = 68;
    localparam int DIV_BITS  = 17;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 51;

    localparam logic [2:0] REG_ANCHOR_X     = 3'd0;
    localparam logic [2:0] REG_ANCHOR_Y     = 3'd1;
    localparam logic [2:0] REG_ANCHOR_Z     = 3'd2;
    localparam logic [2:0] REG_ANCHOR_VEL_X = 3'd3;
    localparam logic [2:0] REG_ANCHOR_VEL_Y = 3'd4;
    localparam logic [2:0] REG_ANCHOR_VEL_Z = 3'd5;
    localparam logic [2:0] REG_ROPE_LENGTH  = 3'd6;

    localparam logic OP_VEL = 1'b0;
    localparam logic OP_POS = 1'b1;

    typedef struct packed {
        logic             op;
        logic             mpos;
        logic [2:0][31:0] p;
        logic [2:0][31:0] v;
        logic [2:0][32:0] d;
        logic [2:0][32:0] r;
    } t_base;

    function automatic logic [31:0] sat32(input logic signed [39:0] x);
        logic [31:0] res;
        if (x > 40'sd2147483647) begin
            res = 32'h7fff_ffff;
        end else if (x < -40'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

>>> design/rope_constraint_projection_top.sv
// ----------------------------------------------------------------------------
// rope_constraint_projection_top
// One-sided rope constraint to an anchor: velocity or position projection.
// ----------------------------------------------------------------------------
// Fully pipelined: one body per cycle while the output is not stalled. Most
// stages belong to the 34-stage square root and the 17-stage restoring
// dividers that form the unit direction; the remaining stages hold the offset,
// squares, dot product and correction multipliers. A stall on the output holds
// the whole pipe in place.
module rope_constraint_projection_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass
    input  logic [223:0] i_s_axis_tdata,
    // opcode
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [191:0] o_m_axis_tdata,
    // applied
    output logic         o_m_axis_tuser
);

    localparam int SB = rcp_pkg::SQRT_BITS;
    localparam int DB = rcp_pkg::DIV_BITS;

    logic [2:0][31:0] r_anchor;
    logic [2:0][31:0] r_anchor_vel;
    logic [30:0]      r_rope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor     <= '0;
            r_anchor_vel <= '0;
            r_rope       <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                rcp_pkg::REG_ANCHOR_X:     r_anchor[0]     <= i_cfg_data;
                rcp_pkg::REG_ANCHOR_Y:     r_anchor[1]     <= i_cfg_data;
                rcp_pkg::REG_ANCHOR_Z:     r_anchor[2]     <= i_cfg_data;
                rcp_pkg::REG_ANCHOR_VEL_X: r_anchor_vel[0] <= i_cfg_data;
                rcp_pkg::REG_ANCHOR_VEL_Y: r_anchor_vel[1] <= i_cfg_data;
                rcp_pkg::REG_ANCHOR_VEL_Z: r_anchor_vel[2] <= i_cfg_data;
                rcp_pkg::REG_ROPE_LENGTH:  r_rope          <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic w_adv;
    logic r_s8_vld;

    assign w_adv           = !r_s8_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // ---- stage 1: offsets
    rcp_pkg::t_base n_s1, r_s1;
    logic           r_s1_vld;
    logic [31:0]    w_mass;

    always_comb begin
        w_mass   = i_s_axis_tdata[223:192];
        n_s1.op   = i_s_axis_tuser;
        n_s1.mpos = !w_mass[31] && (|w_mass);
        for (int i = 0; i < 3; i++) begin
            n_s1.p[i] = i_s_axis_tdata[32*i +: 32];
            n_s1.v[i] = i_s_axis_tdata[96+32*i +: 32];
            n_s1.d[i] = {n_s1.p[i][31], n_s1.p[i]} - {r_anchor[i][31], r_anchor[i]};
            n_s1.r[i] = {n_s1.v[i][31], n_s1.v[i]}
                        - {r_anchor_vel[i][31], r_anchor_vel[i]};
        end
    end

    // ---- stage 2: squares
    rcp_pkg::t_base   r_s2;
    logic             r_s2_vld;
    logic [2:0][63:0] n_s2_sq, r_s2_sq;

    always_comb begin
        logic [32:0] m;
        for (int i = 0; i < 3; i++) begin
            m = r_s1.d[i][32] ? (33'd0 - r_s1.d[i]) : r_s1.d[i];
            n_s2_sq[i] = m[31:0] * m[31:0];
        end
    end

    // ---- stage 3: sum of squares
    rcp_pkg::t_base r_s3;
    logic           r_s3_vld;
    logic [65:0]    r_s3_sum;

    // ---- square root, one result bit per stage
    rcp_pkg::t_base                     r_qb   [SB];
    logic [rcp_pkg::RAD_W-1:0]          r_qrem [SB];
    logic [SB-1:0]                      r_qroot[SB];
    logic [SB-1:0]                      r_qvld;
    logic [rcp_pkg::RAD_W-1:0]          n_qrem [SB];
    logic [SB-1:0]                      n_qroot[SB];

    always_comb begin
        logic [rcp_pkg::RAD_W-1:0] rem_in;
        logic [SB-1:0]             root_in;
        logic [rcp_pkg::RAD_W-1:0] trial;
        for (int k = 0; k < SB; k++) begin
            if (k == 0) begin
                rem_in  = {2'b00, r_s3_sum};
                root_in = '0;
            end else begin
                rem_in  = r_qrem[k-1];
                root_in = r_qroot[k-1];
            end
            trial = ({{(rcp_pkg::RAD_W-SB){1'b0}}, root_in} << (SB - k))
                    | ({{(rcp_pkg::RAD_W-1){1'b0}}, 1'b1} << (2*(SB-1-k)));
            if (rem_in >= trial) begin
                n_qrem[k]  = rem_in - trial;
                n_qroot[k] = root_in | ({{(SB-1){1'b0}}, 1'b1} << (SB-1-k));
            end else begin
                n_qrem[k]  = rem_in;
                n_qroot[k] = root_in;
            end
        end
    end

    // ---- stage 4: slack check, divider setup
    rcp_pkg::t_base   r_s4;
    logic             r_s4_vld, r_s4_go;
    logic [SB:0]      r_s4_e;
    logic [SB-1:0]    r_s4_dist;
    logic [2:0]       r_s4_neg;
    logic [2:0][rcp_pkg::NUM_W-1:0] r_s4_num;
    logic [SB-1:0]    w_dist;
    logic [2:0][rcp_pkg::NUM_W-1:0] n_s4_num;

    assign w_dist = r_qroot[SB-1];

    always_comb begin
        logic [32:0] m;
        for (int i = 0; i < 3; i++) begin
            m = r_qb[SB-1].d[i][32] ? (33'd0 - r_qb[SB-1].d[i]) : r_qb[SB-1].d[i];
            n_s4_num[i] = {m[31:0], 16'd0};
        end
    end

    // ---- restoring dividers, one quotient bit per stage
    rcp_pkg::t_base                  r_vb   [DB];
    logic [2:0][rcp_pkg::NUM_W-1:0]  r_vrem [DB];
    logic [2:0][DB-1:0]              r_vq   [DB];
    logic [DB-1:0]                   r_vgo;
    logic [SB:0]                     r_ve   [DB];
    logic [SB-1:0]                   r_vdist[DB];
    logic [2:0]                      r_vneg [DB];
    logic [DB-1:0]                   r_vvld;
    logic [2:0][rcp_pkg::NUM_W-1:0]  n_vrem [DB];
    logic [2:0][DB-1:0]              n_vq   [DB];

    always_comb begin
        logic [rcp_pkg::NUM_W-1:0] rem_in;
        logic [DB-1:0]             q_in;
        logic [SB-1:0]             dist_in;
        logic [rcp_pkg::DEN_W-1:0] den;
        for (int j = 0; j < DB; j++) begin
            dist_in = (j == 0) ? r_s4_dist : r_vdist[j-1];
            den = {{(rcp_pkg::DEN_W-SB){1'b0}}, dist_in} << (DB-1-j);
            for (int i = 0; i < 3; i++) begin
                rem_in = (j == 0) ? r_s4_num[i] : r_vrem[j-1][i];
                q_in   = (j == 0) ? '0 : r_vq[j-1][i];
                if ({3'b000, rem_in} >= den) begin
                    n_vrem[j][i] = rem_in - den[rcp_pkg::NUM_W-1:0];
                    n_vq[j][i]   = q_in | ({{(DB-1){1'b0}}, 1'b1} << (DB-1-j));
                end else begin
                    n_vrem[j][i] = rem_in;
                    n_vq[j][i]   = q_in;
                end
            end
        end
    end

    // ---- stage 5: direction and first products
    rcp_pkg::t_base   r_s5;
    logic             r_s5_vld, r_s5_go;
    logic [2:0][17:0] r_s5_n, n_s5_n;
    logic [2:0][50:0] r_s5_pr, n_s5_pr;
    logic [2:0][52:0] r_s5_pe, n_s5_pe;

    always_comb begin
        logic [17:0] qx;
        for (int i = 0; i < 3; i++) begin
            qx = {1'b0, r_vq[DB-1][i]};
            n_s5_n[i]  = r_vneg[DB-1][i] ? (18'd0 - qx) : qx;
            n_s5_pr[i] = 51'($signed(n_s5_n[i]) * $signed(r_vb[DB-1].r[i]));
            n_s5_pe[i] = 53'($signed(n_s5_n[i]) * $signed({1'b0, r_ve[DB-1]}));
        end
    end

    // ---- stage 6: dot product, position result
    rcp_pkg::t_base   r_s6;
    logic             r_s6_vld, r_s6_go;
    logic [2:0][17:0] r_s6_n;
    logic [36:0]      r_s6_dv;
    logic [2:0][31:0] r_s6_pn, n_s6_pn;
    logic [52:0]      w_acc;

    always_comb begin
        w_acc = {{2{r_s5_pr[0][50]}}, r_s5_pr[0]} + {{2{r_s5_pr[1][50]}}, r_s5_pr[1]}
                + {{2{r_s5_pr[2][50]}}, r_s5_pr[2]};
        for (int i = 0; i < 3; i++) begin
            n_s6_pn[i] = rcp_pkg::sat32($signed({{8{r_s5.p[i][31]}}, r_s5.p[i]})
                         - $signed({{3{r_s5_pe[i][52]}}, r_s5_pe[i][52:16]}));
        end
    end

    // ---- stage 7: velocity correction products
    rcp_pkg::t_base   r_s7;
    logic             r_s7_vld, r_s7_go, r_s7_dvpos;
    logic [2:0][31:0] r_s7_pn;
    logic [2:0][54:0] r_s7_dvn, n_s7_dvn;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s7_dvn[i] = 55'($signed(r_s6_dv) * $signed(r_s6_n[i]));
        end
    end

    // ---- stage 8: output register
    rcp_pkg::t_base   r_s8;
    logic [2:0][31:0] r_s8_p, r_s8_v, n_s8_p, n_s8_v;
    logic             r_s8_app, n_s8_app;

    always_comb begin
        logic [2:0][31:0] vn;
        for (int i = 0; i < 3; i++) begin
            vn[i] = rcp_pkg::sat32($signed({{8{r_s7.v[i][31]}}, r_s7.v[i]})
                    - $signed({r_s7_dvn[i][54], r_s7_dvn[i][54:16]}));
        end
        n_s8_p   = r_s7.p;
        n_s8_v   = r_s7.v;
        n_s8_app = 1'b0;
        if (r_s7_go) begin
            if (r_s7.op == rcp_pkg::OP_POS) begin
                n_s8_p   = r_s7_pn;
                n_s8_app = 1'b1;
            end else if (r_s7_dvpos && r_s7.mpos) begin
                n_s8_v   = vn;
                n_s8_app = 1'b1;
            end
        end
    end

    // ---- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_qvld   <= '0;
            r_s4_vld <= 1'b0;
            r_vvld   <= '0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_s8_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_s_axis_tvalid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_qvld   <= {r_qvld[SB-2:0], r_s3_vld};
            r_s4_vld <= r_qvld[SB-1];
            r_vvld   <= {r_vvld[DB-2:0], r_s4_vld};
            r_s5_vld <= r_vvld[DB-1];
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
            r_s8_vld <= r_s7_vld;
        end
    end

    // ---- payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1     <= n_s1;
            r_s2     <= r_s1;
            r_s2_sq  <= n_s2_sq;
            r_s3     <= r_s2;
            r_s3_sum <= {2'b00, r_s2_sq[0]} + {2'b00, r_s2_sq[1]} + {2'b00, r_s2_sq[2]};
            for (int k = 0; k < SB; k++) begin
                r_qb[k]    <= (k == 0) ? r_s3 : r_qb[k-1];
                r_qrem[k]  <= n_qrem[k];
                r_qroot[k] <= n_qroot[k];
            end
            r_s4      <= r_qb[SB-1];
            r_s4_go   <= (w_dist != '0) && (w_dist > {3'b000, r_rope});
            r_s4_e    <= {1'b0, w_dist} - {4'b0000, r_rope};
            r_s4_dist <= w_dist;
            r_s4_num  <= n_s4_num;
            for (int i = 0; i < 3; i++) begin
                r_s4_neg[i] <= r_qb[SB-1].d[i][32];
            end
            for (int j = 0; j < DB; j++) begin
                r_vb[j]    <= (j == 0) ? r_s4 : r_vb[j-1];
                r_vgo[j]   <= (j == 0) ? r_s4_go : r_vgo[j-1];
                r_ve[j]    <= (j == 0) ? r_s4_e : r_ve[j-1];
                r_vdist[j] <= (j == 0) ? r_s4_dist : r_vdist[j-1];
                r_vneg[j]  <= (j == 0) ? r_s4_neg : r_vneg[j-1];
                r_vrem[j]  <= n_vrem[j];
                r_vq[j]    <= n_vq[j];
            end
            r_s5       <= r_vb[DB-1];
            r_s5_go    <= r_vgo[DB-1];
            r_s5_n     <= n_s5_n;
            r_s5_pr    <= n_s5_pr;
            r_s5_pe    <= n_s5_pe;
            r_s6       <= r_s5;
            r_s6_go    <= r_s5_go;
            r_s6_n     <= r_s5_n;
            r_s6_dv    <= w_acc[52:16];
            r_s6_pn    <= n_s6_pn;
            r_s7       <= r_s6;
            r_s7_go    <= r_s6_go;
            r_s7_dvpos <= !r_s6_dv[36] && (|r_s6_dv);
            r_s7_pn    <= r_s6_pn;
            r_s7_dvn   <= n_s7_dvn;
            r_s8       <= r_s7;
            r_s8_p     <= n_s8_p;
            r_s8_v     <= n_s8_v;
            r_s8_app   <= n_s8_app;
        end
    end

    assign o_m_axis_tvalid = r_s8_vld;
    assign o_m_axis_tdata  = {r_s8_v, r_s8_p};
    assign o_m_axis_tuser  = r_s8_app;

    // ---- checks
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_s1_vld)
        else $error("accepted transaction did not enter the pipe");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s8_vld && !r_s8_app) |-> (r_s8_p == r_s8.p && r_s8_v == r_s8.v))
        else $error("unapplied transaction was modified");

    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_vld && r_s5_go) |->
        (r_s5_n[0][17] || r_s5_n[0] <= 18'd65536) &&
        (!r_s5_n[0][17] || r_s5_n[0] >= 18'h30000))
        else $error("direction component out of range");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Rope constraint projection: directed and random bodies through both passes,
// several anchor and rope settings, random idling on both streams, results
// checked field by field against a bit-accurate predictor.
// ----------------------------------------------------------------------------
class rope_scoreboard;
    logic [192:0] pending[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    function void note_body(logic [192:0] want);
        pending = {pending, want};
    endfunction

    function void check_body(logic [191:0] data, logic appl);
        logic [192:0] want;
        if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, data);
            errors++;
        end else begin
            want = pending.pop_front();
            for (int i = 0; i < 6; i++) begin
                if (want[i*32 +: 32] !== data[i*32 +: 32]) begin
                    $display("%0t field %0d expected %h actual %h", $time, i,
                             want[i*32 +: 32], data[i*32 +: 32]);
                    errors++;
                end
            end
            if (want[192] !== appl) begin
                $display("%0t applied expected %b actual %b", $time, want[192], appl);
                errors++;
            end
        end
    endfunction
endclass

module testbench;

    logic         i_clk, i_rst_n;
    logic         i_cfg_wen;
    logic [2:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;
    logic         i_s_axis_tvalid, o_s_axis_tready;
    logic [223:0] i_s_axis_tdata;
    logic         i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b1;
    logic [191:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;

    rope_constraint_projection_top u_dut (.*);

    rope_scoreboard sb;
    logic signed [63:0] anc[3], anc_vel[3];
    logic signed [63:0] rope_len;
    int  idle_cycles = 0;
    bit  calm;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    function automatic logic signed [63:0] floor_q16(logic signed [63:0] x);
        return x >>> 16;
    endfunction

    function automatic logic signed [63:0] sat_q32(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic [33:0] isqrt(logic [67:0] rad);
        logic [33:0]  r;
        logic [33:0]  c;
        r = '0;
        for (int i = 33; i >= 0; i--) begin
            c = r | (34'd1 << i);
            if ({34'd0, c} * {34'd0, c} <= rad) r = c;
        end
        return r;
    endfunction

    function automatic logic [192:0] project_body(logic op, logic [223:0] dat);
        logic signed [63:0] p[3], v[3], d[3], n[3];
        logic signed [63:0] mass, acc, dv, e, span;
        logic [67:0]        rad;
        logic [192:0]       res;
        logic               appl;
        appl = 1'b0;
        rad = '0;
        mass = $signed(dat[192 +: 32]);
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(dat[i*32 +: 32]);
            v[i] = $signed(dat[96 + i*32 +: 32]);
            d[i] = p[i] - anc[i];
            rad += {4'd0, 64'(d[i] * d[i])};
        end
        span = $signed({30'd0, isqrt(rad)});
        if (span != 0 && span > rope_len) begin
            for (int i = 0; i < 3; i++) n[i] = (d[i] * 65536) / span;
            if (op == rcp_pkg::OP_VEL) begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += n[i] * (v[i] - anc_vel[i]);
                dv = floor_q16(acc);
                if (dv > 0 && mass > 0) begin
                    for (int i = 0; i < 3; i++) v[i] = sat_q32(v[i] - floor_q16(dv * n[i]));
                    appl = 1'b1;
                end
            end else begin
                e = span - rope_len;
                for (int i = 0; i < 3; i++) p[i] = sat_q32(p[i] - floor_q16(n[i] * e));
                appl = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            res[i*32 +: 32]      = p[i][31:0];
            res[96 + i*32 +: 32] = v[i][31:0];
        end
        res[192] = appl;
        return res;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            rcp_pkg::REG_ANCHOR_X:     anc[0] = $signed(val);
            rcp_pkg::REG_ANCHOR_Y:     anc[1] = $signed(val);
            rcp_pkg::REG_ANCHOR_Z:     anc[2] = $signed(val);
            rcp_pkg::REG_ANCHOR_VEL_X: anc_vel[0] = $signed(val);
            rcp_pkg::REG_ANCHOR_VEL_Y: anc_vel[1] = $signed(val);
            rcp_pkg::REG_ANCHOR_VEL_Z: anc_vel[2] = $signed(val);
            rcp_pkg::REG_ROPE_LENGTH:  rope_len = $signed({33'd0, val[30:0]});
            default: ;
        endcase
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic send_body(logic op, logic [223:0] dat);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= dat;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_body(project_body(op, dat));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
        endcase
    endfunction

    task automatic random_body(int mode);
        logic [223:0] dat;
        for (int i = 0; i < 7; i++) dat[i*32 +: 32] = rand_coord(mode);
        if ($urandom_range(0, 3) == 0) dat[192 +: 32] = $urandom();
        else dat[192 +: 32] = $urandom_range(1, 32'h7fffffff);
        send_body(1'($urandom()), dat);
    endtask

    task automatic directed_bodies();
        logic [223:0] dat;
        logic [31:0] edges[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 7; i++) dat[i*32 +: 32] = edges[(k + i) % 4];
            send_body(rcp_pkg::OP_VEL, dat);
            send_body(rcp_pkg::OP_POS, dat);
        end
        dat = '0;
        send_body(rcp_pkg::OP_VEL, dat);
        send_body(rcp_pkg::OP_POS, dat);
        dat[31:0] = 32'd1;
        send_body(rcp_pkg::OP_POS, dat);
        // outward body with positive, zero and negative mass, then inward
        dat = '0;
        dat[31:0] = 32'd5 << 16; dat[127:96] = 32'd3 << 16; dat[223:192] = 32'd1 << 16;
        send_body(rcp_pkg::OP_VEL, dat);
        dat[223:192] = 32'd0;
        send_body(rcp_pkg::OP_VEL, dat);
        dat[223:192] = 32'hffff_0000;
        send_body(rcp_pkg::OP_VEL, dat);
        dat[223:192] = 32'd1 << 16; dat[127:96] = -(32'd3 << 16);
        send_body(rcp_pkg::OP_VEL, dat);
        send_body(rcp_pkg::OP_POS, dat);
    endtask

    initial begin
        int stalled;
        stalled = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stalled = 0;
            else if (++stalled > 5000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_body(o_m_axis_tdata, o_m_axis_tuser);
    end

    always @(negedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_m_axis_tready <= 1'b1;
        end else if (idle_cycles > 0) begin
            idle_cycles--;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            idle_cycles = $urandom_range(0, 4);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin
        sb = new();
        calm = 1'b0;
        for (int i = 0; i < 3; i++) begin anc[i] = 0; anc_vel[i] = 0; end
        rope_len = 0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0; i_cfg_idx = rcp_pkg::REG_ANCHOR_X; i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0; i_s_axis_tdata = '0; i_s_axis_tuser = rcp_pkg::OP_VEL;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_bodies();
        for (int ph = 0; ph < 6; ph++) begin
            i_s_axis_tvalid <= 1'b0;
            drain();
            if (ph == 1) begin
                write_reg(rcp_pkg::REG_ANCHOR_X, 32'h7fff_ffff);
                write_reg(rcp_pkg::REG_ANCHOR_Y, 32'h8000_0000);
                write_reg(rcp_pkg::REG_ANCHOR_Z, 32'h7fff_ffff);
                write_reg(rcp_pkg::REG_ANCHOR_VEL_X, 32'h8000_0000);
                write_reg(rcp_pkg::REG_ANCHOR_VEL_Y, 32'h7fff_ffff);
                write_reg(rcp_pkg::REG_ANCHOR_VEL_Z, 32'h8000_0000);
                write_reg(rcp_pkg::REG_ROPE_LENGTH, 32'h7fff_ffff);
            end else if (ph == 2) begin
                write_reg(rcp_pkg::REG_ANCHOR_X, 32'h0);
                write_reg(rcp_pkg::REG_ANCHOR_Y, 32'h0);
                write_reg(rcp_pkg::REG_ANCHOR_Z, 32'h0);
                write_reg(rcp_pkg::REG_ROPE_LENGTH, 32'h0);
            end else if (ph >= 3) begin
                for (int r = 0; r < 6; r++)
                    write_reg(3'(r), rand_coord(ph == 5 ? 0 : 1));
                write_reg(rcp_pkg::REG_ROPE_LENGTH, $urandom_range(0, 12 << 16));
            end
            i_cfg_wen <= 1'b0;
            if (ph == 5) calm = 1'b1;
            for (int k = 0; k < 100; k++) random_body(k % 5 == 0 ? 0 : (k % 2 + 1));
        end
        i_s_axis_tvalid <= 1'b0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
